// ===== design/lcg_pkg.sv =====
// Shared types and constants of the linear chirp generator.
// Holds the config register codes, the lookup control struct and the Taylor constants.
// No dependencies; the phase stage, the table stage and the top level import this package.
`timescale 1ns / 1ps

package lcg_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF  = 32;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int INDEX_W  = 24;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [INDEX_W-1:0] SAMPLE_COUNT_RST = 24'd1024;

    // Quarter-wave table generation constants (Q30 fixed point).
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;
    localparam int TAYLOR_TERMS = 10;

    // Divisors (2n-1)*2n of the cosine series, n = 1 .. TAYLOR_TERMS.
    localparam logic [8:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_INC    = 2'd0,
        REG_INC_STEP     = 2'd1,
        REG_SAMPLE_COUNT = 2'd2
    } t_cfg_reg;

    // Control bits that travel with a table address to the output stage.
    typedef struct packed {
        logic               neg;
        logic               zero;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_lookup;

endpackage

// ===== design/lcg_in_if.sv =====
// Input channel of the linear chirp generator: one restart flag per item.
// Depends on nothing; used by the phase stage and the top level.
`timescale 1ns / 1ps

interface lcg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ===== design/lcg_out_if.sv =====
// Output channel of the linear chirp generator: sample, index and last flag.
// Depends on nothing; used by the table stage and the top level.
`timescale 1ns / 1ps

interface lcg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [23:0]        sample_index;
    logic               last;

    modport source (output valid, output sample, output sample_index, output last,
                    input ready);
    modport sink   (input valid, input sample, input sample_index, input last,
                    output ready);
endinterface

// ===== design/lcg_phase.sv =====
// Phase stage: configuration registers, phase and increment accumulators, sweep position.
// Turns each accepted item into a quarter-table address and a registered lookup record.
// Depends on lcg_pkg and lcg_in_if.
`timescale 1ns / 1ps

module lcg_phase #(
    parameter int PHASE_BITS  = lcg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_DEPTH = lcg_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(TABLE_DEPTH)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [lcg_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [lcg_pkg::CFG_W-1:0]               i_cfg_data,
    lcg_in_if.sink                                  i_in,
    input  logic                                    i_advance,
    output logic                                    o_valid,
    output logic [ADDR_W-1:0]                       o_addr,
    output lcg_pkg::t_lookup                        o_lookup
);
    import lcg_pkg::*;

    localparam int REM_W  = PHASE_BITS - 2;
    localparam int PROD_W = REM_W + ADDR_W;

    logic [CFG_W-1:0]         r_start_inc;
    logic signed [CFG_W-1:0]  r_inc_step;
    logic [INDEX_W-1:0]       r_sample_count;

    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic [PHASE_BITS-1:0]    r_increment, n_increment;
    logic [INDEX_W-1:0]       r_position, n_position;

    logic                     r_valid;
    logic [ADDR_W-1:0]        r_addr;
    t_lookup                  r_lookup;

    logic                     w_accept;
    logic [PHASE_BITS-1:0]    w_start_inc;
    logic [PHASE_BITS-1:0]    w_step;
    logic [PHASE_BITS-1:0]    w_cur_phase;
    logic [PHASE_BITS-1:0]    w_cur_inc;
    logic [INDEX_W-1:0]       w_cur_pos;
    logic [INDEX_W-1:0]       w_count;
    logic                     w_last;
    logic [1:0]               w_quad;
    logic [PROD_W-1:0]        w_prod;
    logic [ADDR_W-1:0]        w_idx;
    logic [ADDR_W:0]          w_mirror;
    logic [ADDR_W-1:0]        w_addr;
    t_lookup                  w_lookup;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_inc    <= '0;
            r_inc_step     <= '0;
            r_sample_count <= SAMPLE_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_START_INC:    r_start_inc    <= i_cfg_data;
                REG_INC_STEP:     r_inc_step     <= i_cfg_data;
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_valid || i_advance;
    assign w_accept   = i_in.valid && i_in.ready;

    // Start increment is truncated or zero-extended; the step is sign-extended.
    assign w_start_inc = PHASE_BITS'(r_start_inc);
    assign w_step      = PHASE_BITS'(r_inc_step);

    // A restart puts the sweep back at its start before this item is used.
    assign w_cur_phase = i_in.restart ? '0 : r_phase;
    assign w_cur_inc   = i_in.restart ? w_start_inc : r_increment;
    assign w_cur_pos   = i_in.restart ? '0 : r_position;

    // A zero count behaves as one, so every item ends the sweep.
    assign w_count = (r_sample_count == '0) ? INDEX_W'(1) : r_sample_count;
    assign w_last  = ({1'b0, w_cur_pos} + (INDEX_W+1)'(1)) >= {1'b0, w_count};

    // Accumulator next state.
    always_comb begin
        n_phase     = r_phase;
        n_increment = r_increment;
        n_position  = r_position;
        if (w_accept) begin
            if (w_last) begin
                n_phase     = '0;
                n_increment = w_start_inc;
                n_position  = '0;
            end else begin
                n_phase     = w_cur_phase + w_cur_inc;
                n_increment = w_cur_inc + w_step;
                n_position  = w_cur_pos + INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_increment <= '0;
            r_position  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_increment <= n_increment;
            r_position  <= n_position;
        end
    end

    // Quadrant split and scaling of the remainder onto the table depth.
    assign w_quad   = w_cur_phase[PHASE_BITS-1 -: 2];
    assign w_prod   = PROD_W'(w_cur_phase[REM_W-1:0]) * PROD_W'(TABLE_DEPTH);
    assign w_idx    = w_prod[PROD_W-1 -: ADDR_W];
    assign w_mirror = (ADDR_W+1)'(TABLE_DEPTH) - {1'b0, w_idx};

    // Odd quadrants read the table mirrored; a mirrored index of zero is the zero crossing.
    always_comb begin
        w_addr          = w_quad[0] ? w_mirror[ADDR_W-1:0] : w_idx;
        w_lookup.zero   = w_quad[0] && (w_idx == '0);
        w_lookup.neg    = w_quad[1] ^ w_quad[0];
        w_lookup.index  = w_cur_pos;
        w_lookup.last   = w_last;
        if (w_lookup.zero) begin
            w_addr = '0;
        end
    end

    // Stage register towards the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr   <= w_addr;
            r_lookup <= w_lookup;
        end
    end

    assign o_valid  = r_valid;
    assign o_addr   = r_addr;
    assign o_lookup = r_lookup;

    // The end of a sweep rewinds phase and position.
    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_last |=> r_phase == '0 && r_position == '0)
        else $error("sweep end did not rewind phase and position");

    // Every other item moves the position on by one.
    a_position_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_last |=> r_position == $past(w_cur_pos) + INDEX_W'(1))
        else $error("position did not advance by one");

    // Without an accepted item the accumulators keep their values.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_phase) && $stable(r_position) && $stable(r_increment))
        else $error("accumulator state changed without an item");

    // A stalled lookup record is never dropped.
    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_advance |=> r_valid)
        else $error("stalled lookup record was lost");

endmodule

// ===== design/lcg_rom.sv =====
// Table stage: quarter-wave cosine ROM with a registered read, which is also the output register.
// Applies the quadrant sign and the zero crossing on the way to the output channel.
// Depends on lcg_pkg and lcg_out_if.
`timescale 1ns / 1ps

module lcg_rom #(
    parameter int TABLE_DEPTH = lcg_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(TABLE_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [ADDR_W-1:0]     i_addr,
    input  lcg_pkg::t_lookup      i_lookup,
    output logic                  o_advance,
    lcg_out_if.source             o_out
);
    import lcg_pkg::*;

    // Entry k is round(32767 * cos(pi/2 * k / depth)) from a truncated Q30 Taylor series.
    function automatic logic [MAG_W-1:0] cos_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] scaled;
        longint      acc;
        x    = (PI_HALF_Q30 * 64'(k)) / TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        acc  = longint'(ONE_Q30);
        for (int n = 0; n < TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(ONE_Q30)) begin
            acc = longint'(ONE_Q30);
        end
        scaled = (64'(acc) * FULL_SCALE + (ONE_Q30 >> 1)) >> 30;
        return scaled[MAG_W-1:0];
    endfunction

    logic [MAG_W-1:0]     w_table [TABLE_DEPTH];
    logic                 r_valid;
    logic [MAG_W-1:0]     r_mag;
    t_lookup              r_lookup;
    logic signed [SAMPLE_W-1:0] w_mag;

    // Constant table contents.
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_table
        assign w_table[k] = cos_entry(k);
    end

    // The output register takes a new item whenever it is empty or being drained.
    assign o_advance = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    // Registered table read.
    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_mag    <= w_table[i_addr];
            r_lookup <= i_lookup;
        end
    end

    // Quadrant sign and zero crossing.
    assign w_mag = r_lookup.zero ? '0 : signed'({1'b0, r_mag});

    assign o_out.valid        = r_valid;
    assign o_out.sample       = r_lookup.neg ? -w_mag : w_mag;
    assign o_out.sample_index = r_lookup.index;
    assign o_out.last         = r_lookup.last;

    // A waiting result is not overwritten.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_out.ready |=> r_valid && $stable(r_mag) && $stable(r_lookup))
        else $error("waiting result was overwritten");

    // A record offered while the output drains reaches the output register.
    a_record_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_advance |=> r_valid && r_lookup == $past(i_lookup))
        else $error("lookup record did not reach the output");

    // The zero crossing only arises from the mirrored address zero.
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_lookup.zero |-> i_addr == '0)
        else $error("zero crossing with a nonzero address");

endmodule

// ===== design/linear_chirp_generator_unit.sv =====
// Top level of the linear chirp generator: phase stage followed by the cosine table stage.
// Depends on lcg_pkg, lcg_in_if, lcg_out_if, lcg_phase and lcg_rom.
//
//   Channel   Direction  Payload                        Handshake
//   i_in      in         restart                        valid / ready
//   o_out     out        sample, sample_index, last     valid / ready
//   i_cfg_*   in         index, data (32 bits)          write enable, no wait
//
// One item per clock while o_out is ready; each item is registered in the phase stage, then in the table stage.
// The accumulator update and the scaling of the phase onto the table depth come first,
// then the registered quarter-table read, which feeds the output directly.
// Reset is synchronous and active low and needs no clearing pass; the table is constant.
// A stalled output keeps one result and one more item in the pipeline before i_in.ready drops.
`timescale 1ns / 1ps

module linear_chirp_generator_unit #(
    parameter int TABLE_DEPTH = lcg_pkg::TABLE_DEPTH_DEF,
    parameter int PHASE_BITS  = lcg_pkg::PHASE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [lcg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lcg_pkg::CFG_W-1:0]     i_cfg_data,
    lcg_in_if.sink                        i_in,
    lcg_out_if.source                     o_out
);
    import lcg_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic              w_valid;
    logic              w_advance;
    logic [ADDR_W-1:0] w_addr;
    t_lookup           w_lookup;

    // Accumulators and address generation.
    lcg_phase #(
        .PHASE_BITS  (PHASE_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_advance   (w_advance),
        .o_valid     (w_valid),
        .o_addr      (w_addr),
        .o_lookup    (w_lookup)
    );

    // Cosine table and output register.
    lcg_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid),
        .i_addr    (w_addr),
        .i_lookup  (w_lookup),
        .o_advance (w_advance),
        .o_out     (o_out)
    );

endmodule
